/* sv/prtd_pkg.sv */
// ----------------------------------------------------------------------------
// prtd_pkg
// Shared types and constants for the pending request table.
// ----------------------------------------------------------------------------
package prtd_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_GET = 2'd1,
        OP_DEL = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STAT_ADDED    = 3'd0,
        STAT_OLD      = 3'd1,
        STAT_DUP      = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_REMOVED  = 3'd4,
        STAT_NOTFOUND = 3'd5
    } status_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  device;
        logic [31:0] dest;
        logic [31:0] source;
        logic [31:0] seq;
    } entry_t;

endpackage

/* sv/prtd_table.sv */
// ----------------------------------------------------------------------------
// prtd_table
// Entry storage: one read address and one write port, flip-flop based.
// ----------------------------------------------------------------------------
module prtd_table
    import prtd_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] rd_idx,
    output entry_t           rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  entry_t           wr_data
);

    entry_t entry_reg [TABLE_DEPTH];

    // Slots beyond the live count are never interpreted, so no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_idx];

endmodule

/* sv/pending_request_table_dedup_top.sv */
// Timing: an add runs the age check and then the duplicate scan, and answers early when
// it is dropped as old or as a duplicate; get and delete scan for the id, match or not,
// and close the gap on a match; an unused opcode goes straight to the response.
// Throughput: one item at a time, ready again the cycle after its result is loaded; the
// walk over the table, one slot per cycle through a single compare unit, bounds the rate.
// Reset: asynchronous, clears the entry count, the control state and the output valid.
// ----------------------------------------------------------------------------
// pending_request_table_dedup_top
// Insertion-ordered table of pending route requests with duplicate checks.
// ----------------------------------------------------------------------------
module pending_request_table_dedup_top
    import prtd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // seq_id[31:0], source_ip[63:32], dest_ip[95:64], device_id[103:96],
    // task_handle[119:104]
    input  logic [119:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found_handle[15:0]
    output logic [15:0]  m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    typedef struct packed {
        logic id_eq;
        logic all_eq;
        logic newer_gt;
    } cmp_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    op_t              op_reg, op_next;
    entry_t           key_reg, key_next;
    status_t          res_status_reg, res_status_next;
    logic [15:0]      res_handle_reg, res_handle_next;
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [15:0]      out_handle_reg, out_handle_next;

    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
    cmp_t             cmp;
    logic [CNT_W-1:0] ptr_inc;
    logic             accept;

    prtd_table u_table (
        .clk     (clk),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // The one compare unit, shared by the age check, the duplicate scan and
    // the id search.
    always_comb
    begin
        cmp.id_eq    = (rd_data.seq == key_reg.seq);
        cmp.all_eq   = cmp.id_eq && (rd_data.source == key_reg.source) &&
                       (rd_data.dest == key_reg.dest) &&
                       (rd_data.device == key_reg.device);
        cmp.newer_gt = ($signed(rd_data.seq) > $signed(key_reg.seq));
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        rd_idx          = ptr_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_idx          = ptr_reg[IDX_W-1:0];
        wr_data         = key_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op_t'(s_tuser);
                    key_next        = entry_t'(s_tdata);
                    ptr_next        = '0;
                    res_handle_next = '0;
                    res_status_next = STAT_NOTFOUND;
                    case (s_tuser) inside
                        OP_ADD:          state_next = ST_CHECK;
                        OP_GET, OP_DEL:  state_next = ST_SCAN;
                        default:         state_next = ST_RESP;
                    endcase
                end
            end
            ST_CHECK:
            begin
                // The newest entry sits just below the count.
                rd_idx = IDX_W'(count_reg - CNT_W'(1));
                if ((count_reg != '0) && cmp.newer_gt)
                begin
                    res_status_next = STAT_OLD;
                    state_next      = ST_RESP;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ptr_reg == count_reg)
                begin
                    state_next = ST_RESP;
                    if (op_reg == OP_ADD)
                    begin
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_idx          = count_reg[IDX_W-1:0];
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = STAT_ADDED;
                        end
                    end
                end
                else if (op_reg == OP_ADD)
                begin
                    if (cmp.all_eq)
                    begin
                        res_status_next = STAT_DUP;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        ptr_next = ptr_inc;
                    end
                end
                else if (cmp.id_eq)
                begin
                    if (op_reg == OP_GET)
                    begin
                        res_handle_next = rd_data.handle;
                    end
                    state_next = ST_SHIFT;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            ST_SHIFT:
            begin
                // Close the gap: move the next younger entry down one slot.
                rd_idx = ptr_inc[IDX_W-1:0];
                if (ptr_inc < count_reg)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    ptr_next = ptr_inc;
                end
                else
                begin
                    count_next      = count_reg - CNT_W'(1);
                    res_status_next = STAT_REMOVED;
                    state_next      = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_handle_reg;
    assign m_tuser  = out_status_reg;

    // The table never holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // The count moves by at most one per item.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_next == count_reg) || (count_next == count_reg + CNT_W'(1)) ||
        (count_next + CNT_W'(1) == count_reg))
        else $error("entry count jumped");

    // An accepted beat always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("stayed idle after accepting a beat");

    // The gap closing only runs over live slots.
    a_shift_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (ptr_reg < count_reg))
        else $error("shift pointer outside live entries");

endmodule
